@@ design/sipool_pkg.sv @@
// Shared types, codes and constants for the slot index pool.
package sipool_pkg;

  // Default pool depth and fixed field widths
  localparam int unsigned POOL_SIZE_DEF = 256;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RETURN  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  // Shift controls for the stack chain
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

@@ design/sipool_cell.sv @@
// One stack cell: holds one free index and shifts with its neighbors.
module sipool_cell import sipool_pkg::*; #(
  parameter int unsigned IW      = 8,
  parameter int unsigned RST_VAL = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stack_ctrl_t   ctrl_i,
  input  logic [IW-1:0] prev_i,
  input  logic [IW-1:0] next_i,
  output logic [IW-1:0] entry_o
);

  logic [IW-1:0] entry_q;
  logic [IW-1:0] entry_d;

  // Take the word from above on push, from below on pop, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = prev_i;
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= IW'(RST_VAL);
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ design/sipool_stack.sv @@
// Free index stack built as a chain of shifting cells; cell 0 is the top.
module sipool_stack import sipool_pkg::*; #(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEF,
  parameter int unsigned IW        = $clog2(POOL_SIZE)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stack_ctrl_t   ctrl_i,
  input  logic [IW-1:0] push_data_i,
  output logic [IW-1:0] top_o
);

  logic [IW-1:0] entry [POOL_SIZE];

  // Cell k starts out holding index k, so index 0 sits on top
  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
    logic [IW-1:0] prev;
    logic [IW-1:0] next;

    if (k == 0) begin : g_head
      assign prev = push_data_i;
    end else begin : g_body
      assign prev = entry[k-1];
    end

    if (k == POOL_SIZE - 1) begin : g_tail
      assign next = entry[k];
    end else begin : g_inner
      assign next = entry[k+1];
    end

    sipool_cell #(
      .IW      (IW),
      .RST_VAL (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entry[k])
    );
  end

  assign top_o = entry[0];

endmodule

@@ design/sipool_map.sv @@
// Assigned bitmap in 32-bit words with a top-bit encoder on the read word.
module sipool_map import sipool_pkg::*; #(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEF,
  parameter int unsigned NW        = (POOL_SIZE + WORD_W - 1) / WORD_W,
  parameter int unsigned WIW       = (NW > 1) ? $clog2(NW) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIW-1:0]   rd_word_i,
  input  logic [BIT_W-1:0] rd_bit_i,
  input  logic             wr_en_i,
  input  logic             wr_set_i,
  input  logic [WIW-1:0]   wr_word_i,
  input  logic [BIT_W-1:0] wr_bit_i,
  output logic             bit_o,
  output logic             word_nz_o,
  output logic [BIT_W-1:0] word_top_o
);

  logic [WORD_W-1:0] map_q [NW];
  logic [WORD_W-1:0] rd_data;

  // Locate the highest set bit of a word in five halving steps
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    logic [15:0]      h16;
    logic [7:0]       h8;
    logic [3:0]       h4;
    logic [1:0]       h2;
    r[4] = |w[31:16];
    h16  = r[4] ? w[31:16] : w[15:0];
    r[3] = |h16[15:8];
    h8   = r[3] ? h16[15:8] : h16[7:0];
    r[2] = |h8[7:4];
    h4   = r[2] ? h8[7:4] : h8[3:0];
    r[1] = |h4[3:2];
    h2   = r[1] ? h4[3:2] : h4[1:0];
    r[0] = h2[1];
    return r;
  endfunction

  // Read one word; the index check and the downward scan share this port
  assign rd_data    = map_q[rd_word_i];
  assign bit_o      = rd_data[rd_bit_i];
  assign word_nz_o  = |rd_data;
  assign word_top_o = top_bit(rd_data);

  // Set or clear one bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NW; w++) begin
        map_q[w] <= '0;
      end
    end else if (wr_en_i) begin
      map_q[wr_word_i][wr_bit_i] <= wr_set_i;
    end
  end

endmodule

@@ design/slot_index_pool_with_highest_tracking_top.sv @@
// Top level of the slot index pool: control, counters and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word: opcode_i
//   selects a request (pop a free index) or a return of free_index_i.
//   Output channel (out_valid_o / out_ready_i) carries exactly one result
//   word per input word: granted index, status (ok, pool empty, or return
//   ignored), highest assigned index (0 if none) and assigned count.
//   The operation itself is applied in the cycle the word is accepted; the
//   result then waits in the pending result registers and moves to the
//   output register once that register is free. A return of the current
//   highest index while others stay assigned first passes a scan state:
//   the bitmap is scanned downward one 32-bit word per cycle from the
//   returned index's word. Input is taken again while a finished result
//   still waits at the output register; when the receiver stalls, the
//   next result is held internally and in_ready_o stays low until the
//   output frees up. Reset fills the free stack (index 0 on top), clears
//   the bitmap, and empties the output register; there is no clearing pass.
module slot_index_pool_with_highest_tracking_top import sipool_pkg::*; #(
  parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [IDX_W-1:0]    free_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    highest_assigned_o,
  output logic [COUNT_W-1:0]  assigned_count_o
);

  localparam int unsigned IW  = $clog2(POOL_SIZE);
  localparam int unsigned CW  = $clog2(POOL_SIZE + 1);
  localparam int unsigned NW  = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned WIW = (NW > 1) ? $clog2(NW) : 1;

  state_e             state_q, state_d;
  logic [CW-1:0]      free_cnt_q, free_cnt_d;
  logic [IW-1:0]      highest_q, highest_d;
  logic [WIW-1:0]     scan_w_q, scan_w_d;
  logic [IDX_W-1:0]   res_granted_q, res_granted_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_granted_q;
  status_e            out_status_q;
  logic [IDX_W-1:0]   out_highest_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_load;

  stack_ctrl_t        stack_ctrl;
  logic [IW-1:0]      stack_top;
  logic [IW-1:0]      push_data;

  logic [WIW-1:0]     rd_word;
  logic               map_bit;
  logic               word_nz;
  logic [BIT_W-1:0]   word_top;
  logic               wr_en;
  logic               wr_set;
  logic [WIW-1:0]     wr_word;
  logic [BIT_W-1:0]   wr_bit;

  logic               accept;
  logic [31:0]        idx32;
  logic [31:0]        top32;
  logic [31:0]        idx_word32;
  logic [31:0]        top_word32;
  logic [31:0]        scan_hi32;
  logic [31:0]        count32;
  logic [31:0]        highest32;
  logic               idx_ok;

  // Widen fields once so compares and slices stay explicit
  assign idx32      = {{(32-IDX_W){1'b0}}, free_index_i};
  assign top32      = {{(32-IW){1'b0}}, stack_top};
  assign idx_word32 = idx32 >> BIT_W;
  assign top_word32 = top32 >> BIT_W;
  assign scan_hi32  = ({{(32-WIW){1'b0}}, scan_w_q} << BIT_W)
                    | {{(32-BIT_W){1'b0}}, word_top};
  assign push_data  = idx32[IW-1:0];

  // Take a word only while idle
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Index check: in range, currently assigned, stack not full
  assign idx_ok = (idx32 < POOL_SIZE) && map_bit && (free_cnt_q < CW'(POOL_SIZE));

  // Bitmap read port: scan word while scanning, returned index's word otherwise
  assign rd_word = (state_q == S_SCAN) ? scan_w_q : idx_word32[WIW-1:0];

  sipool_stack #(
    .POOL_SIZE (POOL_SIZE),
    .IW        (IW)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (stack_ctrl),
    .push_data_i (push_data),
    .top_o       (stack_top)
  );

  sipool_map #(
    .POOL_SIZE (POOL_SIZE),
    .NW        (NW),
    .WIW       (WIW)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_word_i  (rd_word),
    .rd_bit_i   (free_index_i[BIT_W-1:0]),
    .wr_en_i    (wr_en),
    .wr_set_i   (wr_set),
    .wr_word_i  (wr_word),
    .wr_bit_i   (wr_bit),
    .bit_o      (map_bit),
    .word_nz_o  (word_nz),
    .word_top_o (word_top)
  );

  // Output register is free when empty or being drained this cycle
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Next state, stack shifts, bitmap writes and tracked highest
  always_comb begin
    state_d       = state_q;
    free_cnt_d    = free_cnt_q;
    highest_d     = highest_q;
    scan_w_d      = scan_w_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    stack_ctrl    = '0;
    wr_en         = 1'b0;
    wr_set        = 1'b0;
    wr_word       = top_word32[WIW-1:0];
    wr_bit        = top32[BIT_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_granted_d = '0;
          res_status_d  = STATUS_OK;
          state_d       = S_OUT;
          if (opcode_e'(opcode_i) == OP_REQUEST) begin
            if (free_cnt_q == '0) begin
              res_status_d = STATUS_EMPTY;
            end else begin
              // Pop the top index and mark it assigned
              stack_ctrl.pop = 1'b1;
              wr_en          = 1'b1;
              wr_set         = 1'b1;
              free_cnt_d     = free_cnt_q - 1'b1;
              res_granted_d  = top32[IDX_W-1:0];
              if (free_cnt_q == CW'(POOL_SIZE) || stack_top > highest_q) begin
                highest_d = stack_top;
              end
            end
          end else begin
            if (!idx_ok) begin
              res_status_d = STATUS_BAD_FREE;
            end else begin
              // Push the index back and clear its bit
              stack_ctrl.push = 1'b1;
              wr_en           = 1'b1;
              wr_set          = 1'b0;
              wr_word         = idx_word32[WIW-1:0];
              wr_bit          = free_index_i[BIT_W-1:0];
              free_cnt_d      = free_cnt_q + 1'b1;
              if (free_cnt_q + 1'b1 == CW'(POOL_SIZE)) begin
                highest_d = '0;
              end else if (idx32 == {{(32-IW){1'b0}}, highest_q}) begin
                scan_w_d = idx_word32[WIW-1:0];
                state_d  = S_SCAN;
              end
            end
          end
        end
      end
      S_SCAN: begin
        // Walk down the bitmap until a word holds an assigned index or word 0 has been read
        if (word_nz) begin
          highest_d = scan_hi32[IW-1:0];
          state_d   = S_OUT;
        end else if (scan_w_q == '0) begin
          highest_d = '0;
          state_d   = S_OUT;
        end else begin
          scan_w_d = scan_w_q - 1'b1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_cnt_q <= CW'(POOL_SIZE);
      highest_q  <= '0;
      scan_w_q   <= '0;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      highest_q  <= highest_d;
      scan_w_q   <= scan_w_d;
    end
  end

  // Pending result fields
  always_ff @(posedge clk_i) begin
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
  end

  assign count32   = 32'(POOL_SIZE) - {{(32-CW){1'b0}}, free_cnt_q};
  assign highest32 = {{(32-IW){1'b0}}, highest_q};

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word, loaded when the slot frees up
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_granted_q <= res_granted_q;
      out_status_q  <= res_status_q;
      out_highest_q <= highest32[IDX_W-1:0];
      out_count_q   <= count32[COUNT_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_index_o    = out_granted_q;
  assign status_o           = out_status_q;
  assign highest_assigned_o = out_highest_q;
  assign assigned_count_o   = out_count_q;

endmodule

@@ dv/tb_slot_index_pool_with_highest_tracking_top.sv @@
// Testbench for the slot index pool: directed table plus random traffic, scored by a predictor.
module tb_slot_index_pool_with_highest_tracking_top;
  import sipool_pkg::*;

  localparam int unsigned POOL_N   = POOL_SIZE_DEF;
  localparam int unsigned N_DIR    = 14;
  localparam int unsigned N_RAND   = 1800;
  localparam int unsigned HOLD_AT  = 700;
  localparam int unsigned HOLD_LEN = 400;

  typedef struct packed {
    logic [IDX_W-1:0]   granted;
    status_e            status;
    logic [IDX_W-1:0]   highest;
    logic [COUNT_W-1:0] count;
  } pool_result_t;

  typedef struct packed {
    opcode_e          op;
    logic [IDX_W-1:0] idx;
    logic             typed;
    pool_result_t     res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                opcode_i = OP_REQUEST;
  logic [IDX_W-1:0]    free_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IDX_W-1:0]    granted_index_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    highest_assigned_o;
  logic [COUNT_W-1:0]  assigned_count_o;

  // Shadow pool state
  logic [IDX_W-1:0]   free_stk [POOL_N];
  logic [COUNT_W-1:0] free_cnt;
  logic [POOL_N-1:0]  busy_map;

  pool_result_t pending_results [$];
  dir_row_t     dir_tbl [N_DIR];
  int unsigned  n_errors   = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_checked  = 0;
  int unsigned  n_grants   = 0;
  int unsigned  n_empty    = 0;
  int unsigned  n_ignored  = 0;
  int unsigned  n_returns  = 0;
  logic         hold_off   = 1'b0;

  slot_index_pool_with_highest_tracking_top #(
    .POOL_SIZE(POOL_N)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .free_index_i       (free_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .granted_index_o    (granted_index_o),
    .status_o           (status_o),
    .highest_assigned_o (highest_assigned_o),
    .assigned_count_o   (assigned_count_o)
  );

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Release reset once
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop
  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Highest assigned index, 0 when none
  function automatic logic [IDX_W-1:0] top_busy_index();
    for (int i = POOL_N - 1; i >= 0; i--) begin
      if (busy_map[i]) return IDX_W'(i);
    end
    return '0;
  endfunction

  // Pick an assigned index at random, or any index when none is assigned
  function automatic logic [IDX_W-1:0] pick_busy_index();
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] j;
    start = IDX_W'($urandom_range(0, POOL_N - 1));
    for (int k = 0; k < POOL_N; k++) begin
      j = start + IDX_W'(k);
      if (busy_map[j]) return j;
    end
    return start;
  endfunction

  // Apply one word to the shadow pool and work out its result
  task automatic pool_apply(input opcode_e op, input logic [IDX_W-1:0] idx,
                            output pool_result_t res);
    logic [IDX_W-1:0] gidx;
    res = '0;
    res.status = STATUS_OK;
    if (op == OP_REQUEST) begin
      if (free_cnt == '0) begin
        res.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        free_cnt = free_cnt - 1'b1;
        gidx = free_stk[free_cnt[IDX_W-1:0]];
        busy_map[gidx] = 1'b1;
        res.granted = gidx;
        n_grants++;
      end
    end else begin
      if (!busy_map[idx] || free_cnt >= COUNT_W'(POOL_N)) begin
        res.status = STATUS_BAD_FREE;
        n_ignored++;
      end else begin
        busy_map[idx] = 1'b0;
        free_stk[free_cnt[IDX_W-1:0]] = idx;
        free_cnt = free_cnt + 1'b1;
        n_returns++;
      end
    end
    res.highest = top_busy_index();
    res.count   = COUNT_W'(POOL_N) - free_cnt;
  endtask

  // Directed words; typed results only where they are obvious
  initial begin
    dir_tbl = '{
      '{OP_REQUEST, 8'd0,   1'b1, '{8'd0, STATUS_OK,       8'd0, 9'd1}},
      '{OP_RETURN,  8'd0,   1'b1, '{8'd0, STATUS_OK,       8'd0, 9'd0}},
      '{OP_RETURN,  8'd0,   1'b1, '{8'd0, STATUS_BAD_FREE, 8'd0, 9'd0}},
      '{OP_RETURN,  8'd255, 1'b1, '{8'd0, STATUS_BAD_FREE, 8'd0, 9'd0}},
      '{OP_REQUEST, 8'd255, 1'b1, '{8'd0, STATUS_OK,       8'd0, 9'd1}},
      '{OP_REQUEST, 8'd0,   1'b1, '{8'd1, STATUS_OK,       8'd1, 9'd2}},
      '{OP_REQUEST, 8'd0,   1'b0, '0},
      '{OP_RETURN,  8'd2,   1'b0, '0},
      '{OP_RETURN,  8'd1,   1'b0, '0},
      '{OP_REQUEST, 8'd0,   1'b0, '0},
      '{OP_REQUEST, 8'd0,   1'b0, '0},
      '{OP_RETURN,  8'd128, 1'b0, '0},
      '{OP_REQUEST, 8'hAA,  1'b0, '0},
      '{OP_RETURN,  8'd0,   1'b0, '0}
    };
  end

  // Sender: directed table, then random phases that fill and drain the pool
  initial begin
    opcode_e          cur_op;
    logic [IDX_W-1:0] cur_idx;
    pool_result_t     res;
    logic             busy;
    int unsigned      n_issued;
    int unsigned      burst_left;
    int unsigned      gap_left;
    int unsigned      phase_left;
    int unsigned      phase_no;
    int unsigned      req_pct;
    int unsigned      pct_list [6];

    pct_list   = '{98, 50, 5, 75, 25, 95};
    busy       = 1'b0;
    n_issued   = 0;
    burst_left = 1;
    gap_left   = 0;
    phase_left = 0;
    phase_no   = 0;
    req_pct    = 50;
    cur_op     = OP_REQUEST;
    cur_idx    = '0;

    for (int k = 0; k < POOL_N; k++) free_stk[k] = IDX_W'(POOL_N - 1 - k);
    free_cnt = COUNT_W'(POOL_N);
    busy_map = '0;

    wait (rst_ni === 1'b1);
    while (n_issued < N_DIR + N_RAND || busy) begin
      @(posedge clk_i);
      // Score the word taken at this edge
      if (busy && in_ready_o) begin
        pool_apply(cur_op, cur_idx, res);
        if (n_accepted < N_DIR && dir_tbl[n_accepted].typed) begin
          res = dir_tbl[n_accepted].res;
        end
        pending_results = {pending_results, res};
        n_accepted++;
        busy = 1'b0;
      end
      // Offer the next word, honoring burst gaps
      if (!busy && n_issued < N_DIR + N_RAND) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          if (n_issued < N_DIR) begin
            cur_op  = dir_tbl[n_issued].op;
            cur_idx = dir_tbl[n_issued].idx;
          end else begin
            if (phase_left == 0) begin
              req_pct    = (phase_no == 0) ? 98 : pct_list[$urandom_range(0, 5)];
              phase_left = $urandom_range(150, 400);
              phase_no++;
            end
            phase_left--;
            if ($urandom_range(0, 99) < req_pct) begin
              cur_op  = OP_REQUEST;
              cur_idx = IDX_W'($urandom_range(0, 255));
            end else begin
              cur_op  = OP_RETURN;
              cur_idx = ($urandom_range(0, 99) < 85) ? pick_busy_index()
                                                     : IDX_W'($urandom_range(0, 255));
            end
          end
          busy = 1'b1;
          n_issued++;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= busy;
      opcode_i     <= cur_op;
      free_index_i <= cur_idx;
    end

    // Drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d words and %0d results: %0d grants, %0d returns,",
             n_accepted, n_checked, n_grants, n_returns);
    $display("  %0d requests on an empty pool, %0d ignored returns.", n_empty, n_ignored);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (n_accepted >= HOLD_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Receiver: stall pattern that switches mode now and then
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    logic        rdy;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        2: rdy = (tick % 4 == 0);
        default: rdy = ($urandom_range(0, 4) != 0);
      endcase
      out_ready_i <= rdy && !hold_off;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: granted %0d status %0d", granted_index_o, status_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (granted_index_o !== want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, granted_index_o);
          n_errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_errors++;
        end
        if (highest_assigned_o !== want.highest) begin
          $error("highest_assigned: expected %0d, got %0d", want.highest, highest_assigned_o);
          n_errors++;
        end
        if (assigned_count_o !== want.count) begin
          $error("assigned_count: expected %0d, got %0d", want.count, assigned_count_o);
          n_errors++;
        end
      end
    end
  end

endmodule

@@ sim.f @@
design/sipool_pkg.sv
design/sipool_cell.sv
design/sipool_stack.sv
design/sipool_map.sv
design/slot_index_pool_with_highest_tracking_top.sv
dv/tb_slot_index_pool_with_highest_tracking_top.sv
